@@ sv/sgr_pkg.sv @@
// Shared constants and types for the sandpile grain relaxation block.
// Used by the row cells, the topple counter and the top level; no dependencies.
package sgr_pkg;

	// grid edge length (2 .. 16); the grid is GRID_SIZE rows of GRID_SIZE cells
	localparam int GRID_SIZE = 16;

	// fixed widths of the payload fields
	localparam int FIELD_W  = 4;
	localparam int SIZE_W   = 24;
	localparam int ROUNDS_W = 16;

	// a relaxing cell never holds more than 7 grains
	localparam int HEIGHT_W = 3;
	localparam logic [HEIGHT_W-1:0] TOPPLE_LIMIT = HEIGHT_W'(3);

	// topple counts: per row, per group of rows, per round
	localparam int CNT_W = $clog2(GRID_SIZE + 1);
	localparam int GROUP = 8;
	localparam int NGRP  = (GRID_SIZE + GROUP - 1) / GROUP;
	localparam int TOT_W = $clog2(GRID_SIZE * GRID_SIZE + 1);

	// row popcount works on chunks of eight flags
	localparam int NCHUNK = (GRID_SIZE + 7) / 8;

	typedef logic [GRID_SIZE-1:0] row_flags_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	// per-row cell control: one relaxation round, or one grain on a column
	typedef struct packed {
		logic               step;
		logic               add;
		logic [FIELD_W-1:0] col;
	} cell_ctl_t;

	// topple counter control
	typedef struct packed {
		logic clear;
		logic step;
	} cnt_ctl_t;

endpackage

@@ sv/sandpile_grain_relaxation.sv @@
// Top level of the sandpile grain relaxation block.
// Instantiates sgr_row_cell (one per grid row) and sgr_topple_counter; uses sgr_pkg.

// Abelian sandpile on a GRID_SIZE x GRID_SIZE grid, heights cleared by reset
// (no clearing pass; the block is ready in the first cycle after reset).
// Each grain transfer drops one grain on (grain_row, grain_col); a position
// outside the grid adds nothing and gives a zero result. The grid then relaxes
// in synchronous rounds, one round per clock: every cell above 3 loses 4 and
// feeds its four neighbors, grains past the edge are lost. One result transfer
// follows each grain: avalanche_size (total topplings) and avalanche_rounds
// (rounds that toppled), both saturating. One grain is worked on at a time:
// the time an item takes is set by the one-round-per-cycle update of the
// row chain plus the two-stage count tree that drains after the last round.
// A finished result waits in the output register while the next grain is
// taken in; a grain finishing before that result is taken holds until the
// register frees.
module sandpile_grain_relaxation (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          grain_valid,
	output logic                          grain_ready,
	input  logic [sgr_pkg::FIELD_W-1:0]   grain_row,
	input  logic [sgr_pkg::FIELD_W-1:0]   grain_col,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [sgr_pkg::SIZE_W-1:0]    avalanche_size,
	output logic [sgr_pkg::ROUNDS_W-1:0]  avalanche_rounds
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RELAX,
		ST_FINISH
	} state_t;

	state_t                        state_q;
	logic                          result_valid_q;
	logic [sgr_pkg::SIZE_W-1:0]    size_q;
	logic [sgr_pkg::ROUNDS_W-1:0]  rounds_q;

	logic                          accept;
	logic                          in_grid;
	logic                          any_unstable;
	logic                          finish_go;
	logic                          cnt_busy;
	logic [sgr_pkg::SIZE_W-1:0]    cnt_size;
	logic [sgr_pkg::ROUNDS_W-1:0]  cnt_rounds;
	sgr_pkg::cnt_ctl_t             cnt_ctl;
	sgr_pkg::cell_ctl_t            cell_ctl  [sgr_pkg::GRID_SIZE];
	sgr_pkg::row_flags_t           topple    [sgr_pkg::GRID_SIZE];
	sgr_pkg::cnt_t                 row_count [sgr_pkg::GRID_SIZE];

	assign grain_ready = (state_q == ST_IDLE);
	assign accept      = grain_valid & grain_ready;
	assign in_grid     = (int'(grain_row) < sgr_pkg::GRID_SIZE)
		&& (int'(grain_col) < sgr_pkg::GRID_SIZE);

	// the grain goes to its row only; every row steps while relaxing
	always_comb begin
		for (int k = 0; k < sgr_pkg::GRID_SIZE; k++) begin
			cell_ctl[k].step = (state_q == ST_RELAX);
			cell_ctl[k].add  = accept && in_grid && (int'(grain_row) == k);
			cell_ctl[k].col  = grain_col;
		end
	end

	// row chain: each row sees the topple flags of the rows next to it,
	// the outer rows see none past the edge
	for (genvar k = 0; k < sgr_pkg::GRID_SIZE; k++) begin : g_row
		sgr_pkg::row_flags_t above;
		sgr_pkg::row_flags_t below;

		if (k == 0) begin : g_top
			assign above = '0;
		end else begin : g_mid_a
			assign above = topple[k-1];
		end
		if (k == sgr_pkg::GRID_SIZE - 1) begin : g_bot
			assign below = '0;
		end else begin : g_mid_b
			assign below = topple[k+1];
		end

		sgr_row_cell u_row (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (cell_ctl[k]),
			.above  (above),
			.below  (below),
			.topple (topple[k]),
			.count  (row_count[k])
		);
	end

	always_comb begin
		any_unstable = 1'b0;
		for (int k = 0; k < sgr_pkg::GRID_SIZE; k++) begin
			any_unstable = any_unstable | (|topple[k]);
		end
	end

	// a round counts only when something toppled; the round with no
	// topples ends relaxation
	assign cnt_ctl.clear = accept;
	assign cnt_ctl.step  = (state_q == ST_RELAX) && any_unstable;

	sgr_topple_counter u_counter (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (cnt_ctl),
		.row_count (row_count),
		.busy      (cnt_busy),
		.size      (cnt_size),
		.rounds    (cnt_rounds)
	);

	// count tree drained and the output register free
	assign finish_go = (state_q == ST_FINISH) && !cnt_busy
		&& (!result_valid_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
			size_q         <= '0;
			rounds_q       <= '0;
		end else begin
			if (finish_go) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RELAX;
					end
				end
				ST_RELAX: begin
					if (!any_unstable) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// wait for the count tree to drain and the output to free
					if (finish_go) begin
						size_q   <= cnt_size;
						rounds_q <= cnt_rounds;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid     = result_valid_q;
	assign avalanche_size   = size_q;
	assign avalanche_rounds = rounds_q;

endmodule

@@ sv/sgr_row_cell.sv @@
// One grid row of the sandpile: GRID_SIZE heights and their toppling logic.
// Trades topple flags with the rows above and below every cycle. Uses sgr_pkg.
module sgr_row_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  sgr_pkg::cell_ctl_t  ctl,
	input  sgr_pkg::row_flags_t above,
	input  sgr_pkg::row_flags_t below,
	output sgr_pkg::row_flags_t topple,
	output sgr_pkg::cnt_t       count
);

	logic [sgr_pkg::HEIGHT_W-1:0]   height_q [sgr_pkg::GRID_SIZE];
	logic [sgr_pkg::HEIGHT_W:0]     sum_c    [sgr_pkg::GRID_SIZE];
	sgr_pkg::row_flags_t            from_left;
	sgr_pkg::row_flags_t            from_right;
	logic [sgr_pkg::NCHUNK*8-1:0]   flags_pad;
	logic [3:0]                     chunk    [sgr_pkg::NCHUNK];

	always_comb begin
		for (int c = 0; c < sgr_pkg::GRID_SIZE; c++) begin
			topple[c] = height_q[c] > sgr_pkg::TOPPLE_LIMIT;
		end
	end

	// bit c of from_left is the left neighbor's flag, and so on
	assign from_left  = topple << 1;
	assign from_right = topple >> 1;

	always_comb begin
		for (int c = 0; c < sgr_pkg::GRID_SIZE; c++) begin
			sum_c[c] = {1'b0, height_q[c]}
				+ (sgr_pkg::HEIGHT_W+1)'(above[c])
				+ (sgr_pkg::HEIGHT_W+1)'(below[c])
				+ (sgr_pkg::HEIGHT_W+1)'(from_left[c])
				+ (sgr_pkg::HEIGHT_W+1)'(from_right[c]);
			if (topple[c]) begin
				sum_c[c] = sum_c[c] - (sgr_pkg::HEIGHT_W+1)'(4);
			end
		end
	end

	// popcount in chunks of eight, then over the chunks
	assign flags_pad = (sgr_pkg::NCHUNK*8)'(topple);

	always_comb begin
		for (int j = 0; j < sgr_pkg::NCHUNK; j++) begin
			chunk[j] = '0;
			for (int b = 0; b < 8; b++) begin
				chunk[j] = chunk[j] + 4'(flags_pad[j*8+b]);
			end
		end
		count = '0;
		for (int j = 0; j < sgr_pkg::NCHUNK; j++) begin
			count = count + sgr_pkg::CNT_W'(chunk[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < sgr_pkg::GRID_SIZE; c++) begin
				height_q[c] <= '0;
			end
		end else begin
			for (int c = 0; c < sgr_pkg::GRID_SIZE; c++) begin
				if (ctl.add && (int'(ctl.col) == c)) begin
					height_q[c] <= height_q[c] + sgr_pkg::HEIGHT_W'(1);
				end else if (ctl.step) begin
					height_q[c] <= sum_c[c][sgr_pkg::HEIGHT_W-1:0];
				end
			end
		end
	end

endmodule

@@ sv/sgr_topple_counter.sv @@
// Avalanche statistics: sums the row topple counts of each round over a
// two-stage registered tree into saturating size and round counters. Uses sgr_pkg.
module sgr_topple_counter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sgr_pkg::cnt_ctl_t             ctl,
	input  sgr_pkg::cnt_t                 row_count [sgr_pkg::GRID_SIZE],
	output logic                          busy,
	output logic [sgr_pkg::SIZE_W-1:0]    size,
	output logic [sgr_pkg::ROUNDS_W-1:0]  rounds
);

	sgr_pkg::cnt_t                 cnt_s1   [sgr_pkg::GRID_SIZE];
	logic [sgr_pkg::TOT_W-1:0]     grp_sum  [sgr_pkg::NGRP];
	logic [sgr_pkg::TOT_W-1:0]     grp_s2   [sgr_pkg::NGRP];
	logic [sgr_pkg::TOT_W-1:0]     round_tot;
	logic [sgr_pkg::SIZE_W:0]      size_wide;
	logic [sgr_pkg::SIZE_W-1:0]    size_nxt;
	logic                          v_s1;
	logic                          v_s2;
	logic [sgr_pkg::SIZE_W-1:0]    size_q;
	logic [sgr_pkg::ROUNDS_W-1:0]  rounds_q;

	always_comb begin
		for (int g = 0; g < sgr_pkg::NGRP; g++) begin
			grp_sum[g] = '0;
		end
		for (int i = 0; i < sgr_pkg::GRID_SIZE; i++) begin
			grp_sum[i / sgr_pkg::GROUP] = grp_sum[i / sgr_pkg::GROUP]
				+ sgr_pkg::TOT_W'(cnt_s1[i]);
		end
	end

	always_comb begin
		round_tot = '0;
		for (int g = 0; g < sgr_pkg::NGRP; g++) begin
			round_tot = round_tot + grp_s2[g];
		end
		size_wide = {1'b0, size_q} + (sgr_pkg::SIZE_W+1)'(round_tot);
		// carry out means the sum passed the maximum: hold at all ones
		size_nxt  = size_wide[sgr_pkg::SIZE_W] ? '1 : size_wide[sgr_pkg::SIZE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			cnt_s1 <= row_count;
		end
		if (v_s1) begin
			grp_s2 <= grp_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			size_q   <= '0;
			rounds_q <= '0;
		end else if (ctl.clear) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			size_q   <= '0;
			rounds_q <= '0;
		end else begin
			v_s1 <= ctl.step;
			v_s2 <= v_s1;
			if (v_s2) begin
				size_q <= size_nxt;
			end
			if (ctl.step && (rounds_q != '1)) begin
				rounds_q <= rounds_q + sgr_pkg::ROUNDS_W'(1);
			end
		end
	end

	assign busy   = v_s1 | v_s2;
	assign size   = size_q;
	assign rounds = rounds_q;

endmodule

@@ bench/sandpile_grain_relaxation_tb.sv @@
// Self-checking bench for sandpile_grain_relaxation: directed grains, then random fill.
// Depends on sgr_pkg (grid size, field widths, topple limit) and the block's RTL.

module sandpile_grain_relaxation_tb;

	localparam int CELLS       = sgr_pkg::GRID_SIZE * sgr_pkg::GRID_SIZE;
	localparam int TOPPLE_LOSS = 4;
	localparam logic [sgr_pkg::SIZE_W-1:0]   SIZE_SAT   = '1;
	localparam logic [sgr_pkg::ROUNDS_W-1:0] ROUNDS_SAT = '1;
	localparam int RANDOM_GRAINS = 1580;

	// one avalanche as reported on the result channel
	typedef struct {
		logic [sgr_pkg::SIZE_W-1:0]   size;
		logic [sgr_pkg::ROUNDS_W-1:0] rounds;
	} avalanche_t;

	logic                          clk;
	logic                          arst_n;
	logic                          grain_valid;
	logic                          grain_ready;
	logic [sgr_pkg::FIELD_W-1:0]   grain_row;
	logic [sgr_pkg::FIELD_W-1:0]   grain_col;
	logic                          result_valid;
	logic                          result_ready;
	logic [sgr_pkg::SIZE_W-1:0]    avalanche_size;
	logic [sgr_pkg::ROUNDS_W-1:0]  avalanche_rounds;

	// bench copy of the grid, kept in step with every accepted grain
	logic [sgr_pkg::HEIGHT_W-1:0] pile [CELLS];

	// avalanches predicted but not yet seen on the result channel
	avalanche_t avalanche_q[$];

	int n_grains;
	int n_results;
	int n_errors;
	int n_avalanches;      // results with at least one toppling
	int biggest_size;
	int longest_rounds;
	int burst_left;
	int stall_ctr;

	sandpile_grain_relaxation DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.grain_valid      (grain_valid),
		.grain_ready      (grain_ready),
		.grain_row        (grain_row),
		.grain_col        (grain_col),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.avalanche_size   (avalanche_size),
		.avalanche_rounds (avalanche_rounds)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Drop one grain on the bench grid and relax it round by round. Every round
	// works from a snapshot, so all topplings of a round happen at once; grains
	// pushed past the open edge simply vanish. Both counts saturate.
	function automatic avalanche_t drop_grain(input logic [sgr_pkg::FIELD_W-1:0] r,
			input logic [sgr_pkg::FIELD_W-1:0] c);
		logic [sgr_pkg::HEIGHT_W-1:0] nxt [CELLS];
		int unsigned topples;
		int unsigned size_acc;
		int unsigned rounds_acc;
		int rr;
		int cc;
		int idx;
		avalanche_t res;

		size_acc   = 0;
		rounds_acc = 0;
		// a position past the grid edge adds nothing; the grid stays stable
		if (r < sgr_pkg::GRID_SIZE && c < sgr_pkg::GRID_SIZE) begin
			idx = r * sgr_pkg::GRID_SIZE + c;
			pile[idx] = pile[idx] + sgr_pkg::HEIGHT_W'(1);
			do begin
				nxt     = pile;
				topples = 0;
				for (rr = 0; rr < sgr_pkg::GRID_SIZE; rr++) begin
					for (cc = 0; cc < sgr_pkg::GRID_SIZE; cc++) begin
						idx = rr * sgr_pkg::GRID_SIZE + cc;
						if (pile[idx] > sgr_pkg::TOPPLE_LIMIT) begin
							topples++;
							nxt[idx] = nxt[idx] - sgr_pkg::HEIGHT_W'(TOPPLE_LOSS);
							if (rr > 0)
								nxt[idx - sgr_pkg::GRID_SIZE] =
									nxt[idx - sgr_pkg::GRID_SIZE] + sgr_pkg::HEIGHT_W'(1);
							if (rr < sgr_pkg::GRID_SIZE - 1)
								nxt[idx + sgr_pkg::GRID_SIZE] =
									nxt[idx + sgr_pkg::GRID_SIZE] + sgr_pkg::HEIGHT_W'(1);
							if (cc > 0)
								nxt[idx - 1] = nxt[idx - 1] + sgr_pkg::HEIGHT_W'(1);
							if (cc < sgr_pkg::GRID_SIZE - 1)
								nxt[idx + 1] = nxt[idx + 1] + sgr_pkg::HEIGHT_W'(1);
						end
					end
				end
				pile = nxt;
				if (topples != 0) begin
					if (topples >= SIZE_SAT - size_acc)
						size_acc = 32'(SIZE_SAT);
					else
						size_acc = size_acc + topples;
					if (rounds_acc < ROUNDS_SAT)
						rounds_acc++;
				end
			end while (topples != 0);
		end
		res.size   = size_acc[sgr_pkg::SIZE_W-1:0];
		res.rounds = rounds_acc[sgr_pkg::ROUNDS_W-1:0];
		return res;
	endfunction

	// Present one grain and hold it until the transfer. Valid is left high on
	// return so that back-to-back grains never drop it within a burst; only a
	// gap between bursts, or a wait in await_settled, lowers it.
	task automatic send_grain(input logic [sgr_pkg::FIELD_W-1:0] r,
			input logic [sgr_pkg::FIELD_W-1:0] c);
		int gap;

		grain_row   <= r;
		grain_col   <= c;
		grain_valid <= 1'b1;
		do
			@(posedge clk);
		while (!grain_ready);
		avalanche_q.insert(avalanche_q.size(), drop_grain(r, c));
		n_grains++;

		// sender pacing: bursts of random length, now and then a long one
		if (burst_left == 0) begin
			gap = $urandom_range(1, 12);
			grain_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			if ($urandom_range(0, 7) == 0)
				burst_left = $urandom_range(100, 300);
			else
				burst_left = $urandom_range(1, 30);
		end else begin
			burst_left--;
		end
	endtask

	// Stop sending until every predicted avalanche has come back.
	task automatic await_settled();
		grain_valid <= 1'b0;
		while (avalanche_q.size() != 0)
			@(posedge clk);
	endtask

	// Extremes of both fields: the four corners and two middle cells. The grid
	// is empty, so none of these topple. A 4-bit field always lands inside the
	// grid of 16 by 16 cells, so the off-grid case cannot be driven at this size.
	task automatic test_field_extremes();
		send_grain(4'd0, 4'd0);
		send_grain(4'd15, 4'd15);
		send_grain(4'd0, 4'd15);
		send_grain(4'd15, 4'd0);
		send_grain(4'd7, 4'd8);
		send_grain(4'd8, 4'd7);
	endtask

	// First topplings: a corner (two grains lost over the edge), the opposite
	// corner, then a middle cell that feeds all four neighbors.
	task automatic test_first_topples();
		repeat (3) send_grain(4'd0, 4'd0);
		repeat (3) send_grain(4'd15, 4'd15);
		repeat (3) send_grain(4'd7, 4'd8);
	endtask

	// Topple on a straight edge after a full drain, so the block starts idle.
	task automatic test_edge_topple();
		await_settled();
		repeat (4) send_grain(4'd0, 4'd8);
	endtask

	// Random fill. Mostly uniform grains, which bring the grid to its critical
	// state after a few hundred, mixed with clusters in a small window that
	// pile up local avalanches early. One full drain is taken midway.
	task automatic test_random_fill();
		int k;
		int wr;
		int wc;
		int n;
		int j;
		bit drained;

		k       = 0;
		drained = 1'b0;
		while (k < RANDOM_GRAINS) begin
			if (!drained && k >= RANDOM_GRAINS / 2) begin
				await_settled();
				drained = 1'b1;
			end
			if ($urandom_range(0, 9) < 7) begin
				send_grain(sgr_pkg::FIELD_W'($urandom_range(0, sgr_pkg::GRID_SIZE - 1)),
					sgr_pkg::FIELD_W'($urandom_range(0, sgr_pkg::GRID_SIZE - 1)));
				k++;
			end else begin
				wr = $urandom_range(0, sgr_pkg::GRID_SIZE - 4);
				wc = $urandom_range(0, sgr_pkg::GRID_SIZE - 4);
				n  = $urandom_range(2, 8);
				for (j = 0; j < n; j++)
					send_grain(sgr_pkg::FIELD_W'(wr + $urandom_range(0, 3)),
						sgr_pkg::FIELD_W'(wc + $urandom_range(0, 3)));
				k = k + n;
			end
		end
	endtask

	// Receiver stalls: bits 9:8 of a free-running counter pick the pattern: always
	// ready, coin flip, periodic one-in-eight stall, and mostly stalled.
	always @(posedge clk) begin
		stall_ctr <= stall_ctr + 1;
		case (stall_ctr[9:8])
			2'd0: begin
				result_ready <= 1'b1;
			end
			2'd1: begin
				result_ready <= $urandom_range(0, 1);
			end
			2'd2: begin
				result_ready <= (stall_ctr[2:0] != 3'd0);
			end
			default: begin
				result_ready <= ($urandom_range(0, 3) == 0);
			end
		endcase
	end

	// Result checker: each transfer against the oldest predicted avalanche.
	always @(posedge clk) begin : check_results
		avalanche_t want;

		if (arst_n && result_valid && result_ready) begin
			n_results++;
			if (avalanche_q.size() == 0) begin
				n_errors++;
				$display("%0t: result with no grain pending: size %0d rounds %0d",
					$time, avalanche_size, avalanche_rounds);
			end else begin
				want = avalanche_q.pop_front();
				if (avalanche_size !== want.size) begin
					n_errors++;
					$display("%0t: avalanche_size mismatch: expected %0d, actual %0d",
						$time, want.size, avalanche_size);
				end
				if (avalanche_rounds !== want.rounds) begin
					n_errors++;
					$display("%0t: avalanche_rounds mismatch: expected %0d, actual %0d",
						$time, want.rounds, avalanche_rounds);
				end
				if (want.size != 0)
					n_avalanches++;
				if (want.size > biggest_size)
					biggest_size = want.size;
				if (want.rounds > longest_rounds)
					longest_rounds = want.rounds;
			end
		end
	end

	// Hard limit, far above the slowest legal run.
	initial begin
		#50000000;
		$display("sandpile_grain_relaxation verification failed");
		$finish;
	end

	initial begin
		int i;

		for (i = 0; i < CELLS; i++)
			pile[i] = '0;
		n_grains     = 0;
		burst_left   = $urandom_range(1, 30);
		arst_n      <= 1'b0;
		grain_valid <= 1'b0;
		grain_row   <= '0;
		grain_col   <= '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_first_topples();
		test_edge_topple();
		test_random_fill();

		// all grains sent: wait for the last results, then let the
		// count tree drain
		await_settled();
		repeat (16) @(posedge clk);

		$display("Dropped %0d grains, checked %0d results; %0d avalanches,",
			n_grains, n_results, n_avalanches);
		$display("largest %0d topplings, longest %0d rounds, %0d errors.",
			biggest_size, longest_rounds, n_errors);
		if (n_errors == 0 && avalanche_q.size() == 0)
			$display("sandpile_grain_relaxation verification clean");
		else
			$display("sandpile_grain_relaxation verification failed");
		$finish;
	end

endmodule
